// ===== hdl/bpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared types and constants of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned PAGE_COUNT  = 4096;
  localparam int unsigned ORDER_COUNT = 11;
  localparam int unsigned PAGE_W      = 12;
  localparam int unsigned LINK_W      = 13;
  localparam int unsigned ORD_W       = 4;
  localparam int unsigned REG_W       = 13;
  localparam int unsigned META_W      = ORD_W + 1;

  localparam logic [ORD_W-1:0]  SUPER_ORDER = 4'd10;
  localparam logic [ORD_W-1:0]  TOP_ORDER   = 4'd10;
  localparam logic [ORD_W-1:0]  ORDER_LIMIT = 4'd11;
  localparam logic [LINK_W-1:0] LINK_NONE   = 13'h1000;
  localparam logic [PAGE_W-1:0] LAST_PAGE   = 12'hFFF;

  localparam logic [1:0] KIND_ALLOC      = 2'd0;
  localparam logic [1:0] KIND_FREE       = 2'd1;
  localparam logic [1:0] KIND_FREE_SUPER = 2'd2;

  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_NO_BLOCK  = 2'd1;
  localparam logic [1:0] STS_TOO_LARGE = 2'd2;
  localparam logic [1:0] STS_IGNORED   = 2'd3;

  localparam logic CFG_LOW  = 1'b0;
  localparam logic CFG_HIGH = 1'b1;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ORD_W-1:0]  order;
    logic [PAGE_W-1:0] page_index;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] block_index;
    logic [1:0]        status;
  } rsp_t;

  typedef struct packed {
    logic       cap;
    logic       clr_wr;
    logic       scan_inc;
    logic       load_pu;
    logic       lnk_wr;
    logic       split;
    logic       mark_a;
    logic       meta_rd_p;
    logic       load_k;
    logic       brd;
    logic       load_u_b;
    logic       merge;
    logic       mrd;
    logic       mwr;
    logic       load_x_p;
    logic       push1;
    logic       push2;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       res_set;
    logic [1:0] res_code;
    logic       res_blk;
  } dp_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic       head_valid;
    logic       k_top;
    logic       k_gt;
    logic       b_in;
    logic       mark_last;
    logic       idx_out;
    logic       chk_ok;
    logic       bud_ok;
    logic       win_in;
    logic       ord_bad_in;
    logic       is_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// ===== hdl/bpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// ===== hdl/bpa_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_datapath
// Free-list heads, page metadata and link memories, working registers.
// ----------------------------------------------------------------------------
module bpa_datapath (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire                       cfg_idx_i,
  input  wire [bpa_pkg::REG_W-1:0]  cfg_data_i,
  input  bpa_pkg::req_t             req_i,
  input  bpa_pkg::dp_cmd_t          cmd_i,
  output bpa_pkg::dp_sts_t          sts_o,
  output bpa_pkg::rsp_t             rsp_o
);
  import bpa_pkg::*;

  logic [REG_W-1:0]  low_q, high_q;
  logic [LINK_W-1:0] heads_q [ORDER_COUNT];
  logic [1:0]        kind_q;
  logic [ORD_W-1:0]  ord_q, k_q;
  logic [PAGE_W-1:0] p_q, u_q, b_q, x_q, cnt_q, blk_q;
  logic [LINK_W-1:0] h_q;
  logic [1:0]        res_q;

  logic              meta_we;
  logic [PAGE_W-1:0] meta_waddr, meta_raddr;
  logic [META_W-1:0] meta_wdata, meta_rd;
  logic              nxt_we, prv_we;
  logic [PAGE_W-1:0] nxt_waddr, prv_waddr;
  logic [LINK_W-1:0] nxt_wdata, prv_wdata, nxt_rd, prv_rd;

  logic [LINK_W-1:0] head_k;
  logic [ORD_W-1:0]  km1, kp1;
  logic [LINK_W-1:0] b_sum, idx;
  logic [PAGE_W-1:0] size_m1, b_flip, pmin;
  logic [REG_W-1:0]  pi_ext, b_ext;

  assign head_k  = heads_q[k_q];
  assign km1     = k_q - 4'd1;
  assign kp1     = k_q + 4'd1;
  assign b_sum   = {1'b0, p_q} + (13'd1 << km1);
  assign idx     = {1'b0, p_q} + {1'b0, cnt_q};
  assign size_m1 = (12'd1 << k_q) - 12'd1;
  assign b_flip  = p_q ^ (12'd1 << k_q);
  assign pmin    = (b_q < p_q) ? b_q : p_q;
  assign pi_ext  = {1'b0, req_i.page_index};
  assign b_ext   = {1'b0, b_q};

  always_comb begin
    sts_o.clr_last   = (cnt_q == LAST_PAGE);
    sts_o.head_valid = !head_k[LINK_W-1];
    sts_o.k_top      = (k_q == TOP_ORDER);
    sts_o.k_gt       = (k_q > ord_q);
    sts_o.b_in       = !b_sum[LINK_W-1];
    // alloc marks 2^order pages, free marks 2^k pages
    sts_o.mark_last  = (kind_q == KIND_ALLOC) ? (cnt_q == ((12'd1 << ord_q) - 12'd1))
                                               : (cnt_q == size_m1);
    sts_o.idx_out    = idx[LINK_W-1];
    sts_o.chk_ok     = meta_rd[META_W-1] &&
                       !(kind_q == KIND_FREE_SUPER && meta_rd[ORD_W-1:0] != SUPER_ORDER);
    sts_o.bud_ok     = (b_ext >= low_q) && (b_ext < high_q) &&
                       (meta_rd[ORD_W-1:0] == k_q) && !meta_rd[META_W-1];
    sts_o.win_in     = (pi_ext >= low_q) && (pi_ext < high_q);
    sts_o.ord_bad_in = (req_i.order >= ORDER_LIMIT);
    sts_o.is_free    = (kind_q != KIND_ALLOC);
  end

  always_comb begin
    meta_raddr = p_q;
    if (cmd_i.brd) begin
      meta_raddr = b_flip;
    end else if (cmd_i.mrd) begin
      meta_raddr = idx[PAGE_W-1:0];
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = idx[PAGE_W-1:0];
    meta_wdata = {1'b1, ord_q};
    if (cmd_i.clr_wr) begin
      meta_we    = 1'b1;
      meta_waddr = cnt_q;
      meta_wdata = {1'b1, 4'd0};
    end else if (cmd_i.split) begin
      meta_we    = !b_sum[LINK_W-1];
      meta_waddr = b_sum[PAGE_W-1:0];
      meta_wdata = {1'b0, km1};
    end else if (cmd_i.mark_a) begin
      meta_we    = !idx[LINK_W-1];
      meta_wdata = {1'b1, (cnt_q == '0) ? ord_q : 4'd0};
    end else if (cmd_i.merge) begin
      meta_we    = 1'b1;
      meta_waddr = pmin;
      meta_wdata = {1'b0, kp1};
    end else if (cmd_i.mwr) begin
      // clear the allocated bit, keep the recorded order
      meta_we    = 1'b1;
      meta_wdata = {1'b0, meta_rd[ORD_W-1:0]};
    end
  end

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = prv_rd[PAGE_W-1:0];
    nxt_wdata = nxt_rd;
    prv_we    = 1'b0;
    prv_waddr = nxt_rd[PAGE_W-1:0];
    prv_wdata = prv_rd;
    if (cmd_i.lnk_wr) begin
      nxt_we = !prv_rd[LINK_W-1];
      prv_we = !nxt_rd[LINK_W-1];
    end else if (cmd_i.push1) begin
      nxt_we    = 1'b1;
      nxt_waddr = x_q;
      nxt_wdata = head_k;
      prv_we    = 1'b1;
      prv_waddr = x_q;
      prv_wdata = LINK_NONE;
    end else if (cmd_i.push2) begin
      prv_we    = !h_q[LINK_W-1];
      prv_waddr = h_q[PAGE_W-1:0];
      prv_wdata = {1'b0, x_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= 13'd1024;
      high_q <= 13'd4096;
      cnt_q  <= '0;
      for (int i = 0; i < ORDER_COUNT; i++) begin
        heads_q[i] <= LINK_NONE;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LOW:  low_q  <= cfg_data_i;
          CFG_HIGH: high_q <= cfg_data_i;
          default:  ;
        endcase
      end
      if (cmd_i.cnt_clr) begin
        cnt_q <= '0;
      end else if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + 12'd1;
      end
      if (cmd_i.lnk_wr && prv_rd[LINK_W-1]) begin
        heads_q[k_q] <= nxt_rd;
      end else if (cmd_i.push1) begin
        heads_q[k_q] <= {1'b0, x_q};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q <= req_i.kind;
      ord_q  <= req_i.order;
      k_q    <= req_i.order;
      p_q    <= req_i.page_index;
    end
    if (cmd_i.scan_inc) k_q <= kp1;
    if (cmd_i.load_pu) begin
      p_q <= head_k[PAGE_W-1:0];
      u_q <= head_k[PAGE_W-1:0];
    end
    if (cmd_i.split) begin
      k_q <= km1;
      x_q <= b_sum[PAGE_W-1:0];
    end
    if (cmd_i.load_k) begin
      k_q <= (meta_rd[ORD_W-1:0] > TOP_ORDER) ? TOP_ORDER : meta_rd[ORD_W-1:0];
    end
    if (cmd_i.brd) b_q <= b_flip;
    if (cmd_i.load_u_b) u_q <= b_q;
    if (cmd_i.merge) begin
      p_q <= pmin;
      k_q <= kp1;
    end
    if (cmd_i.load_x_p) x_q <= p_q;
    if (cmd_i.push1) h_q <= head_k;
    if (cmd_i.res_set) begin
      res_q <= cmd_i.res_code;
      blk_q <= cmd_i.res_blk ? p_q : '0;
    end
  end

  assign rsp_o.block_index = blk_q;
  assign rsp_o.status      = res_q;

  bpa_ram #(.WIDTH(META_W), .DEPTH(PAGE_COUNT)) u_meta (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (meta_raddr),
    .rdata_o (meta_rd)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_next (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (u_q),
    .rdata_o (nxt_rd)
  );

  bpa_ram #(.WIDTH(LINK_W), .DEPTH(PAGE_COUNT)) u_prev (
    .clk_i   (clk_i),
    .we_i    (prv_we),
    .waddr_i (prv_waddr),
    .wdata_i (prv_wdata),
    .raddr_i (u_q),
    .rdata_o (prv_rd)
  );

endmodule
`default_nettype wire

// ===== hdl/bpa_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer for metadata clearing, allocate and free requests.
// ----------------------------------------------------------------------------
module bpa_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  input  bpa_pkg::req_t      req_i,
  input  bpa_pkg::dp_sts_t   sts_i,
  output bpa_pkg::dp_cmd_t   cmd_o,
  output logic               busy,
  output logic               result_valid_o
);
  import bpa_pkg::*;

  localparam logic [4:0] S_CLEAR  = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_RESULT = 5'd2;
  localparam logic [4:0] S_SCAN   = 5'd3;
  localparam logic [4:0] S_U_RD   = 5'd4;
  localparam logic [4:0] S_U_WR   = 5'd5;
  localparam logic [4:0] S_SPLIT  = 5'd6;
  localparam logic [4:0] S_AMARK  = 5'd7;
  localparam logic [4:0] S_P1     = 5'd8;
  localparam logic [4:0] S_P2     = 5'd9;
  localparam logic [4:0] S_F_RD   = 5'd10;
  localparam logic [4:0] S_F_CHK  = 5'd11;
  localparam logic [4:0] S_F_BRD  = 5'd12;
  localparam logic [4:0] S_F_BCHK = 5'd13;
  localparam logic [4:0] S_F_MRG  = 5'd14;
  localparam logic [4:0] S_F_MRD  = 5'd15;
  localparam logic [4:0] S_F_MWR  = 5'd16;

  logic [4:0] state_q, state_d;

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RESULT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_wr  = 1'b1;
        cmd_o.cnt_inc = 1'b1;
        if (sts_i.clr_last) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_o.cap = 1'b1;
          unique case (req_i.kind) inside
            KIND_ALLOC: begin
              if (sts_i.ord_bad_in) begin
                cmd_o.res_set  = 1'b1;
                cmd_o.res_code = STS_TOO_LARGE;
                state_d        = S_RESULT;
              end else begin
                state_d = S_SCAN;
              end
            end
            KIND_FREE, KIND_FREE_SUPER: begin
              if (sts_i.win_in) begin
                state_d = S_F_RD;
              end else begin
                cmd_o.res_set  = 1'b1;
                cmd_o.res_code = STS_IGNORED;
                state_d        = S_RESULT;
              end
            end
            default: begin
              cmd_o.res_set  = 1'b1;
              cmd_o.res_code = STS_IGNORED;
              state_d        = S_RESULT;
            end
          endcase
        end
      end
      S_RESULT: state_d = S_IDLE;
      S_SCAN: begin
        if (sts_i.head_valid) begin
          cmd_o.load_pu = 1'b1;
          state_d       = S_U_RD;
        end else if (sts_i.k_top) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_NO_BLOCK;
          state_d        = S_RESULT;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      S_U_RD: state_d = S_U_WR;
      S_U_WR: begin
        cmd_o.lnk_wr = 1'b1;
        state_d      = sts_i.is_free ? S_F_MRG : S_SPLIT;
      end
      S_SPLIT: begin
        if (sts_i.k_gt) begin
          cmd_o.split = 1'b1;
          if (sts_i.b_in) state_d = S_P1;
        end else begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_AMARK;
        end
      end
      S_AMARK: begin
        cmd_o.mark_a = 1'b1;
        if (sts_i.mark_last) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_DONE;
          cmd_o.res_blk  = 1'b1;
          state_d        = S_RESULT;
        end else begin
          cmd_o.cnt_inc = 1'b1;
        end
      end
      S_P1: begin
        cmd_o.push1 = 1'b1;
        state_d     = S_P2;
      end
      S_P2: begin
        cmd_o.push2 = 1'b1;
        if (sts_i.is_free) begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_DONE;
          state_d        = S_RESULT;
        end else begin
          state_d = S_SPLIT;
        end
      end
      S_F_RD: begin
        cmd_o.meta_rd_p = 1'b1;
        state_d         = S_F_CHK;
      end
      S_F_CHK: begin
        if (sts_i.chk_ok) begin
          cmd_o.load_k = 1'b1;
          state_d      = S_F_BRD;
        end else begin
          cmd_o.res_set  = 1'b1;
          cmd_o.res_code = STS_IGNORED;
          state_d        = S_RESULT;
        end
      end
      S_F_BRD: begin
        if (sts_i.k_top) begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_F_MRD;
        end else begin
          cmd_o.brd = 1'b1;
          state_d   = S_F_BCHK;
        end
      end
      S_F_BCHK: begin
        if (sts_i.bud_ok) begin
          cmd_o.load_u_b = 1'b1;
          state_d        = S_U_RD;
        end else begin
          cmd_o.cnt_clr = 1'b1;
          state_d       = S_F_MRD;
        end
      end
      S_F_MRG: begin
        cmd_o.merge = 1'b1;
        state_d     = S_F_BRD;
      end
      S_F_MRD: begin
        // pages past the store end the sweep
        if (sts_i.idx_out) begin
          cmd_o.load_x_p = 1'b1;
          state_d        = S_P1;
        end else begin
          cmd_o.mrd = 1'b1;
          state_d   = S_F_MWR;
        end
      end
      S_F_MWR: begin
        cmd_o.mrd = 1'b1;
        cmd_o.mwr = 1'b1;
        if (sts_i.mark_last) begin
          cmd_o.load_x_p = 1'b1;
          state_d        = S_P1;
        end else begin
          cmd_o.cnt_inc = 1'b1;
          state_d       = S_F_MRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/buddy_page_allocator_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// buddy_page_allocator_unit
// Buddy page allocator over 4096 pages with eleven free-list orders.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its page metadata memory with busy high, marking
// every page allocated at order 0. An item is taken when start is high and busy
// low; exactly one result follows on rsp_o, marked by result_valid_o for one
// cycle, and it cannot be held off. One item at a time runs through a sequencer
// over single-port-write memories: an allocate scans up the orders for a free
// block, splits it down one order at a time and then marks its 2^order pages;
// a free merges with its buddy one order at a time, then reads and rewrites the
// metadata of each page of the final block (up to 1024 pages), one page at a time.
module buddy_page_allocator_unit (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      start,
  input  bpa_pkg::req_t            req_i,
  output logic                     busy,
  output logic                     result_valid_o,
  output bpa_pkg::rsp_t            rsp_o,
  input  wire                      cfg_we_i,
  input  wire                      cfg_idx_i,
  input  wire [bpa_pkg::REG_W-1:0] cfg_data_i
);
  import bpa_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  bpa_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_i          (req_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  bpa_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .rsp_o      (rsp_o)
  );

endmodule
`default_nettype wire
